// ----- design/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int FIFO_DEPTH = 4;

	// classifier result for '=' and every character outside the alphabet
	localparam logic [6:0] SEXTET_BAD = 7'd64;

	localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
	localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
	localparam logic [1:0] LAST_IDX_THREE = 2'd2;

	// one command from the front: up to three output words
	typedef struct packed {
		logic [2:0][7:0] bytes;     // bytes[0] goes out first
		logic [1:0]      last_idx;  // index of the final word of this command
		logic            valid;     // 0 for the empty end marker
		logic            done;      // command closes the message
	} cmd_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [6:0] v;
		v = SEXTET_BAD;
		if (ch >= 8'h41 && ch <= 8'h5A)
			v = 7'(ch - 8'h41);
		else if (ch >= 8'h61 && ch <= 8'h7A)
			v = 7'(ch - 8'h61 + 8'd26);
		else if (ch >= 8'h30 && ch <= 8'h39)
			v = 7'(ch - 8'h30 + 8'd52);
		else if (ch == 8'h2B)
			v = 7'd62;
		else if (ch == 8'h2F)
			v = 7'd63;
		return v;
	endfunction

endpackage

// ----- design/b64d_if.sv -----
// ----------------------------------------------------------------------------
// b64d_char_if / b64d_res_if
// Valid/ready channels for input characters and decoded result words.
// ----------------------------------------------------------------------------
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       msg_end;

	modport source (output valid, output char_in, output msg_end, input ready);
	modport sink   (input valid, input char_in, input msg_end, output ready);
endinterface

interface b64d_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       byte_valid;
	logic       msg_done;
	logic       run_last;

	modport source (output valid, output byte_out, output byte_valid,
		output msg_done, output run_last, input ready);
	modport sink   (input valid, input byte_out, input byte_valid,
		input msg_done, input run_last, output ready);
endinterface

// ----- design/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, collects sextets and issues byte commands to the queue.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	b64d_char_if.sink           chars,
	input  logic                full,
	output logic                push,
	output b64d_pkg::cmd_t      push_cmd
);

	logic [17:0] buf_q, buf_n;
	logic [1:0]  cnt_q, cnt_n;
	logic        halt_q, halt_n;
	logic [6:0]  sx;
	logic [23:0] grp;
	logic        emit_grp;
	logic        need_push;
	logic        accept;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;
	assign push        = accept && need_push;

	always_comb begin
		sx       = b64d_pkg::sextet_of(chars.char_in);
		grp      = {buf_q, sx[5:0]};
		buf_n    = buf_q;
		cnt_n    = cnt_q;
		halt_n   = halt_q;
		emit_grp = 1'b0;

		if (!halt_q) begin
			if (sx[6]) begin
				halt_n = 1'b1;
			end else if (cnt_q == 2'd3) begin
				emit_grp = 1'b1;
				buf_n    = '0;
				cnt_n    = '0;
			end else begin
				buf_n = {buf_q[11:0], sx[5:0]};
				cnt_n = cnt_q + 2'd1;
			end
		end

		push_cmd.bytes[0] = grp[23:16];
		push_cmd.bytes[1] = grp[15:8];
		push_cmd.bytes[2] = grp[7:0];
		push_cmd.last_idx = b64d_pkg::LAST_IDX_THREE;
		push_cmd.valid    = 1'b1;
		push_cmd.done     = 1'b0;
		need_push         = emit_grp;

		if (chars.msg_end) begin
			push_cmd.done = 1'b1;
			need_push     = 1'b1;
			// flush a partial group; one leftover sextet is dropped
			if (!emit_grp) begin
				unique case (cnt_n)
					2'd2: begin
						push_cmd.bytes[0] = buf_n[11:4];
						push_cmd.last_idx = b64d_pkg::LAST_IDX_ONE;
					end
					2'd3: begin
						push_cmd.bytes[0] = buf_n[17:10];
						push_cmd.bytes[1] = buf_n[9:2];
						push_cmd.last_idx = b64d_pkg::LAST_IDX_TWO;
					end
					default: begin
						push_cmd.bytes[0] = '0;
						push_cmd.last_idx = b64d_pkg::LAST_IDX_ONE;
						push_cmd.valid    = 1'b0;
					end
				endcase
			end
			buf_n  = '0;
			cnt_n  = '0;
			halt_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			cnt_q  <= '0;
			halt_q <= 1'b0;
		end else if (accept) begin
			buf_q  <= buf_n;
			cnt_q  <= cnt_n;
			halt_q <= halt_n;
		end
	end

endmodule

// ----- design/b64d_fifo.sv -----
// ----------------------------------------------------------------------------
// b64d_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module b64d_fifo #(
	parameter int DEPTH = b64d_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::cmd_t push_cmd,
	input  logic           pop,
	output b64d_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	b64d_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_pop;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == DEPTH_C);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if ((push && !full) && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (!(push && !full) && do_pop)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- design/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Walks the head command one word per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64d_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	b64d_res_if.source     results
);

	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       bvld_q, done_q, last_q;
	logic       slot_free;
	logic       take;
	logic       at_last;

	assign slot_free = !vld_q || results.ready;
	assign take      = slot_free && !empty;
	assign at_last   = (idx_q == head.last_idx);
	assign pop       = take && at_last;

	assign results.valid      = vld_q;
	assign results.byte_out   = byte_q;
	assign results.byte_valid = bvld_q;
	assign results.msg_done   = done_q;
	assign results.run_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (slot_free) begin
			vld_q <= !empty;
			if (!empty)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= head.bytes[idx_q];
			bvld_q <= head.valid;
			done_q <= head.done && at_last;
			last_q <= at_last;
		end
	end

endmodule

// ----- design/base64_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder, one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// One character is accepted per cycle whenever the command queue has room;
// the front classifies it and updates the sextet buffer in that same cycle.
// Results leave through a single output register at one word per cycle while
// the output is not stalled, so a steady stream of full groups runs at one
// character per cycle (three words per four chars). The queue of FIFO_DEPTH
// commands absorbs output stalls before the input ready drops. A completed
// group's first word passes through the command queue and then the output
// register.
module base64_stream_decoder_top #(
	parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	b64d_char_if.sink   chars,
	b64d_res_if.source  results
);

	logic           push, pop, empty, full;
	b64d_pkg::cmd_t push_cmd, head;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	b64d_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

endmodule

// ----- design/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic       byte_valid,
	input logic       msg_done,
	input logic       run_last
);

	// the empty marker only ever closes a message
	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> msg_done && run_last && byte_out == 8'd0)
		else $error("empty marker without end flags");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_done |-> run_last)
		else $error("msg_done on a word that is not the last of its item");

	// fields are fully known while a word is offered
	a_known_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({byte_out, byte_valid, msg_done, run_last}))
		else $error("unknown bits on an offered word");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) &&
		$stable(byte_valid) && $stable(msg_done) && $stable(run_last))
		else $error("stalled word changed");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.byte_out   (results.byte_out),
	.byte_valid (results.byte_valid),
	.msg_done   (results.msg_done),
	.run_last   (results.run_last)
);
